>>> design/bdq_pkg.sv
`default_nettype none

package bdq_pkg;

  localparam int unsigned BDQ_CAPACITY = 64;
  localparam int unsigned DATA_W       = 8;
  localparam int unsigned REQ_W        = 3;
  localparam int unsigned STATUS_W     = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_NONE       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // per-step control broadcast to every cell of one chain
  typedef struct packed {
    logic shr;  // shift toward the tail, new byte enters cell 0
    logic shl;  // shift toward cell 0, head byte leaves
    logic wr;   // write the byte into the cell whose index equals the count
  } bdq_ctl_t;

endpackage

`default_nettype wire

>>> design/bdq_req_if.sv
`default_nettype none

interface bdq_req_if;
  import bdq_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, req_type, data_in, input ready);
  modport sink   (input valid, req_type, data_in, output ready);
endinterface

`default_nettype wire

>>> design/bdq_rsp_if.sv
`default_nettype none

interface bdq_rsp_if #(
  parameter int unsigned OCC_W = $clog2(bdq_pkg::BDQ_CAPACITY + 1)
);
  import bdq_pkg::*;

  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   popped;
  logic [DATA_W-1:0]   front_byte;
  logic [DATA_W-1:0]   back_byte;
  logic [OCC_W-1:0]    occupancy;
  logic [STATUS_W-1:0] status;

  modport source (output valid, popped, front_byte, back_byte, occupancy, status,
                  input ready);
  modport sink   (input valid, popped, front_byte, back_byte, occupancy, status,
                  output ready);
endinterface

`default_nettype wire

>>> design/bdq_cell.sv
`default_nettype none

module bdq_cell
  import bdq_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  wire logic              clk_i,
  input  wire bdq_ctl_t          ctl_i,
  input  wire logic [CNT_W-1:0]  cnt_i,
  input  wire logic [DATA_W-1:0] byte_i,
  input  wire logic [DATA_W-1:0] prev_i,
  input  wire logic [DATA_W-1:0] next_i,
  output logic      [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.shr) begin
      data_d = prev_i;
    end else if (ctl_i.shl) begin
      data_d = next_i;
    end else if (ctl_i.wr && (cnt_i == CNT_W'(IDX))) begin
      data_d = byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

>>> design/bdq_chain.sv
`default_nettype none

module bdq_chain
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = BDQ_CAPACITY,
  parameter int unsigned CNT_W = 7
) (
  input  wire logic              clk_i,
  input  wire bdq_ctl_t          ctl_i,
  input  wire logic [CNT_W-1:0]  cnt_i,
  input  wire logic [DATA_W-1:0] byte_i,
  output logic      [DATA_W-1:0] head_o
);

  logic [DATA_W-1:0] data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] prev;
    logic [DATA_W-1:0] next;

    if (i == 0) begin : g_first
      assign prev = byte_i;
    end else begin : g_mid
      assign prev = data[i-1];
    end

    // the last cell keeps its own byte on a left shift
    if (i == DEPTH - 1) begin : g_last
      assign next = data[i];
    end else begin : g_inner
      assign next = data[i+1];
    end

    bdq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl_i),
      .cnt_i  (cnt_i),
      .byte_i (byte_i),
      .prev_i (prev),
      .next_i (next),
      .data_o (data[i])
    );
  end

  assign head_o = data[0];

endmodule

`default_nettype wire

>>> design/byte_deque_top.sv
`default_nettype none

// Fixed-capacity byte deque built from two rows of shift cells: the front row holds the
// deque front-to-back with the front byte in cell 0, the back row holds it back-to-front
// with the back byte in cell 0. A push at one end shifts that end's row and writes the
// byte at index count in the other row; a pop shifts its own row and leaves the other
// alone, so both ends are always read from cell 0. An item is taken into a pending stage,
// and its result is formed from the updated cells into an output register; with the
// response side ready the block sustains one item per cycle, and a held result
// stalls input after one further item. Occupancy width must equal clog2(CAPACITY+1) on
// the response interface. Storage needs no clearing after reset.
module byte_deque_top
  import bdq_pkg::*;
#(
  parameter int unsigned CAPACITY = BDQ_CAPACITY
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bdq_req_if.sink    req_i,
  bdq_rsp_if.source  rsp_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pend_q;
  logic             out_valid_q;

  logic [DATA_W-1:0]   popped_q, popped_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic [DATA_W-1:0]   out_popped_q, out_front_q, out_back_q;
  logic [CNT_W-1:0]    out_occ_q;
  logic [STATUS_W-1:0] out_status_q;

  logic [DATA_W-1:0] front_head, back_head;
  bdq_ctl_t          ctl_front, ctl_back;

  logic acc, pend_go;
  logic push_b, pop_b, push_f, pop_f;
  logic full, empty;

  assign pend_go = pend_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !pend_q || pend_go;
  assign acc = req_i.valid && req_i.ready;

  assign push_b = (req_i.req_type == REQ_PUSH_BACK);
  assign pop_b  = (req_i.req_type == REQ_POP_BACK);
  assign push_f = (req_i.req_type == REQ_PUSH_FRONT);
  assign pop_f  = (req_i.req_type == REQ_POP_FRONT);
  assign full   = (cnt_q == CNT_W'(CAPACITY));
  assign empty  = (cnt_q == '0);

  always_comb begin
    ctl_front.shr = acc && push_f && !full;
    ctl_front.shl = acc && pop_f && !empty;
    ctl_front.wr  = acc && push_b && !full;
    ctl_back.shr  = acc && push_b && !full;
    ctl_back.shl  = acc && pop_b && !empty;
    ctl_back.wr   = acc && push_f && !full;
  end

  always_comb begin
    cnt_d    = cnt_q;
    popped_d = '0;
    status_d = ST_OK;
    if (push_b || push_f) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end else if (pop_b || pop_f) begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        cnt_d    = cnt_q - CNT_W'(1);
        popped_d = pop_f ? front_head : back_head;
      end
    end
  end

  bdq_chain #(
    .DEPTH (CAPACITY),
    .CNT_W (CNT_W)
  ) u_front (
    .clk_i  (clk_i),
    .ctl_i  (ctl_front),
    .cnt_i  (cnt_q),
    .byte_i (req_i.data_in),
    .head_o (front_head)
  );

  bdq_chain #(
    .DEPTH (CAPACITY),
    .CNT_W (CNT_W)
  ) u_back (
    .clk_i  (clk_i),
    .ctl_i  (ctl_back),
    .cnt_i  (cnt_q),
    .byte_i (req_i.data_in),
    .head_o (back_head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        cnt_q  <= cnt_d;
        pend_q <= 1'b1;
      end else if (pend_go) begin
        pend_q <= 1'b0;
      end
      if (pend_go) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload: step results wait in the pending stage until the cells have settled
  always_ff @(posedge clk_i) begin
    if (acc) begin
      popped_q <= popped_d;
      status_q <= status_d;
    end
    if (pend_go) begin
      out_popped_q <= popped_q;
      out_status_q <= status_q;
      out_occ_q    <= cnt_q;
      out_front_q  <= empty ? '0 : front_head;
      out_back_q   <= empty ? '0 : back_head;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.popped     = out_popped_q;
  assign rsp_o.front_byte = out_front_q;
  assign rsp_o.back_byte  = out_back_q;
  assign rsp_o.occupancy  = out_occ_q;
  assign rsp_o.status     = out_status_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> $stable(cnt_q))
    else $error("occupancy changed without an item");

  a_pend_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> pend_q)
    else $error("accepted item not pending");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_EMPTY) |-> (out_popped_q == '0 && out_occ_q == '0))
    else $error("empty pop result inconsistent");
`endif

endmodule

`default_nettype wire
